FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion helpers for the checker.
`define CHK_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

FILE: design/hng_pkg.sv
`timescale 1ns / 1ps
package hng_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int Y_TERM        = 512;
    localparam int Q_ONE         = 16384;
    localparam int DIV_STEPS     = 30;
    localparam int SQRT_STEPS    = 15;
    localparam logic REG_WIDTH   = 1'b0;
    localparam logic REG_COUNT   = 1'b1;
endpackage

FILE: design/heightmap_normal_generator.sv
`timescale 1ns / 1ps
// Heightmap normal generator.
// Input beats (op, height) carry a raster of signed Q8.8 heights, row by row;
// an input beat is taken when in_valid is high and in_stall is low. Each sample
// from the second row on yields the unit normal of the point one row above,
// and once the frame is complete each drain beat (op = 1) yields one normal of
// the final row. Samples in the first row, samples after the frame and early
// drain beats yield nothing. Output beats carry Q1.14 components and are taken
// when out_valid is high and out_stall is low.
// A beat that yields a normal keeps in_stall high after it is taken, through
// three line buffer reads, two squarings, then for each of the three
// components a 30-step restoring divider followed by a 15-step square root
// unit, shared. No new beat is taken until the normal has been loaded into
// the output register. A beat that yields nothing leaves in_stall low.
// in_stall is high while a normal is in progress; a finished normal waits
// in the output register while the next beat is taken, and a stalled output
// holds until the receiver takes it.
// Reset returns all counters to the start of a frame with row_width 1024 and
// row_count 1; the line buffers are not cleared. Any register write restarts
// the frame.
module heightmap_normal_generator #(
    parameter int MAX_WIDTH = hng_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic signed [15:0] height,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] normal_x,
    output logic [14:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic        last_of_run,
    output logic        end_of_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hng_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_RD3, S_DIFF, S_SQX, S_SQZ,
        S_MAG, S_DIV, S_SQRT, S_OUT
    } state_t;

    state_t state_reg;
    logic [10:0] row_width_reg;
    logic [15:0] row_count_reg;
    logic [AW-1:0] col_reg, drain_reg, x_reg;
    logic [15:0] row_reg;
    logic is_drain_reg, has_up_reg, eof_reg;
    logic [1:0] k_reg;
    logic [4:0] step_reg;

    logic signed [15:0] mid_mem [MAX_WIDTH];
    logic signed [15:0] old_mem [MAX_WIDTH];
    logic signed [15:0] mid_q, old_q;

    logic signed [15:0] h_reg, c_reg, up_reg, right_reg, recent_reg;
    logic signed [16:0] dx_reg, dz_reg;
    logic [32:0] sqx_reg;
    logic [33:0] s_reg, rem_reg;
    logic [29:0] quo_reg, n_reg, bit_reg;
    logic [30:0] res_reg;
    logic [15:0] nx_reg, ny_reg, nz_reg;

    logic [WW-1:0] w_eff;
    logic [15:0] rows_eff;
    logic cfg_wr, accept, out_take, out_load;
    logic [AW-1:0] x_acc, rd_addr, wr_addr;
    logic [WW-1:0] x_acc_p1;
    logic mid_we, old_we;
    logic signed [15:0] mid_wd;
    logic frame_done;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_WIDTH) ? {21'd0, row_width_reg} : {16'd0, row_count_reg};
    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;
    assign out_load = (state_reg == S_OUT) && (!out_valid || out_take);
    assign last_of_run = 1'b1;

    always_comb
    begin
        if (row_width_reg == 11'd0)
            w_eff = WW'(1);
        else if (32'(row_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(row_width_reg);
        rows_eff = (row_count_reg == 16'd0) ? 16'd1 : row_count_reg;
        frame_done = (row_reg >= rows_eff);
        x_acc = op ? drain_reg : col_reg;
        if (WW'(x_acc) >= w_eff)
            x_acc = AW'(w_eff - WW'(1));
        x_acc_p1 = WW'(x_acc) + WW'(1);
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = x_acc;
            S_RD1:   rd_addr = AW'(x_reg + AW'(1));
            default: rd_addr = AW'(x_reg - AW'(1));
        endcase
        mid_we = 1'b0;
        old_we = 1'b0;
        mid_wd = height;
        wr_addr = x_acc;
        if (state_reg == S_IDLE && accept && !cfg_wr && !op && !frame_done
            && row_reg == 16'd0)
            mid_we = 1'b1;
        if (state_reg == S_DIFF && !is_drain_reg)
        begin
            mid_we = 1'b1;
            old_we = 1'b1;
            mid_wd = h_reg;
            wr_addr = x_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_q <= mid_mem[rd_addr];
        old_q <= old_mem[rd_addr];
        if (mid_we)
            mid_mem[wr_addr] <= mid_wd;
        if (old_we)
            old_mem[wr_addr] <= c_reg;
    end

    logic signed [15:0] left_v, right_v, up_v, down_v;
    logic [15:0] mag;
    logic neg;
    logic [34:0] rem2;
    logic [30:0] trial;
    logic sq_take;
    logic [30:0] res_step;
    logic [15:0] rnd, comp;
    logic [WW-1:0] xr_p1;

    always_comb
    begin
        xr_p1 = WW'(x_reg) + WW'(1);
        right_v = (xr_p1 < w_eff) ? right_reg : c_reg;
        up_v = has_up_reg ? up_reg : c_reg;
        if (x_reg == '0)
            left_v = c_reg;
        else
            left_v = is_drain_reg ? mid_q : recent_reg;
        down_v = is_drain_reg ? c_reg : h_reg;
        case (k_reg)
            2'd0:    begin mag = dx_reg[16] ? 16'(-dx_reg) : 16'(dx_reg); neg = dx_reg[16]; end
            2'd1:    begin mag = 16'(Y_TERM); neg = 1'b0; end
            default: begin mag = dz_reg[16] ? 16'(-dz_reg) : 16'(dz_reg); neg = dz_reg[16]; end
        endcase
        rem2 = {rem_reg, 1'b0};
        trial = res_reg + 31'(bit_reg);
        sq_take = ({1'b0, n_reg} >= trial);
        res_step = sq_take ? (res_reg >> 1) + 31'(bit_reg) : res_reg >> 1;
        rnd = 16'((res_step + 31'd1) >> 1);
        comp = neg ? 16'(-rnd) : rnd;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                h_reg <= height;
            end
            S_RD1:
            begin
                c_reg <= mid_q;
                up_reg <= old_q;
            end
            S_RD2:
            begin
                right_reg <= mid_q;
            end
            S_DIFF:
            begin
                dx_reg <= 17'(left_v) - 17'(right_v);
                dz_reg <= 17'(up_v) - 17'(down_v);
                if (!is_drain_reg)
                    recent_reg <= c_reg;
            end
            S_SQX:
            begin
                sqx_reg <= 33'(dx_reg * dx_reg);
            end
            S_SQZ:
            begin
                s_reg <= 34'(sqx_reg) + 34'(dz_reg * dz_reg) + 34'(Y_TERM * Y_TERM);
            end
            S_MAG:
            begin
                rem_reg <= 34'(mag * mag);
                quo_reg <= '0;
            end
            S_DIV:
            begin
                if (rem2 >= {1'b0, s_reg})
                begin
                    rem_reg <= 34'(rem2 - {1'b0, s_reg});
                    quo_reg <= {quo_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[33:0];
                    quo_reg <= {quo_reg[28:0], 1'b0};
                end
                n_reg <= {quo_reg[28:0], rem2 >= {1'b0, s_reg}};
                res_reg <= '0;
                bit_reg <= 30'd1 << 28;
            end
            S_SQRT:
            begin
                if (sq_take)
                    n_reg <= 30'({1'b0, n_reg} - trial);
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
                if (step_reg == 5'(SQRT_STEPS - 1))
                begin
                    if (k_reg == 2'd0)
                        nx_reg <= comp;
                    if (k_reg == 2'd1)
                        ny_reg <= comp;
                    if (k_reg == 2'd2)
                        nz_reg <= comp;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_width_reg <= 11'd1024;
            row_count_reg <= 16'd1;
            col_reg <= '0;
            drain_reg <= '0;
            row_reg <= '0;
            x_reg <= '0;
            is_drain_reg <= 1'b0;
            has_up_reg <= 1'b0;
            eof_reg <= 1'b0;
            k_reg <= '0;
            step_reg <= '0;
            out_valid <= 1'b0;
            normal_x <= '0;
            normal_y <= '0;
            normal_z <= '0;
            end_of_frame <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid <= 1'b1;
            else if (out_take)
                out_valid <= 1'b0;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_WIDTH)
                    row_width_reg <= pwdata[10:0];
                else
                    row_count_reg <= pwdata[15:0];
                col_reg <= '0;
                drain_reg <= '0;
                row_reg <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && !cfg_wr)
                    begin
                        x_reg <= x_acc;
                        is_drain_reg <= op;
                        if (!op && !frame_done)
                        begin
                            has_up_reg <= (row_reg >= 16'd2);
                            eof_reg <= 1'b0;
                            if (x_acc_p1 >= w_eff)
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + 16'd1;
                                drain_reg <= '0;
                            end
                            else
                                col_reg <= AW'(x_acc_p1);
                            if (row_reg != 16'd0)
                                state_reg <= S_RD1;
                        end
                        else if (op && frame_done)
                        begin
                            has_up_reg <= (rows_eff > 16'd1);
                            eof_reg <= (x_acc_p1 >= w_eff);
                            if (x_acc_p1 >= w_eff)
                            begin
                                col_reg <= '0;
                                row_reg <= '0;
                                drain_reg <= '0;
                            end
                            else
                                drain_reg <= AW'(x_acc_p1);
                            state_reg <= S_RD1;
                        end
                    end
                end
                S_RD1:  state_reg <= S_RD2;
                S_RD2:  state_reg <= S_RD3;
                S_RD3:  state_reg <= S_DIFF;
                S_DIFF: state_reg <= S_SQX;
                S_SQX:  state_reg <= S_SQZ;
                S_SQZ:
                begin
                    k_reg <= 2'd0;
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    step_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (step_reg == 5'(DIV_STEPS - 1))
                    begin
                        step_reg <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                S_SQRT:
                begin
                    if (step_reg == 5'(SQRT_STEPS - 1))
                    begin
                        if (k_reg == 2'd2)
                            state_reg <= S_OUT;
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                            state_reg <= S_MAG;
                        end
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        normal_x <= nx_reg;
                        normal_y <= ny_reg[14:0];
                        normal_z <= nz_reg;
                        end_of_frame <= eof_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/hng_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hng_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic signed [15:0] normal_x,
    input logic [14:0] normal_y,
    input logic        last_of_run
);
    import hng_pkg::*;

    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(normal_x))
    `CHK_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid)
    `CHK_IMPLY(a_last, clk, rst_n, out_valid, last_of_run)
    `CHK_IMPLY(a_y_range, clk, rst_n, out_valid, normal_y != 15'd0 && 32'(normal_y) <= Q_ONE)
    `CHK_IMPLY(a_x_range, clk, rst_n, out_valid, normal_x >= -16'sd16384 && normal_x <= 16'sd16384)
endmodule

bind heightmap_normal_generator hng_checker u_hng_checker (.*);
